// ----- rtl/core/ehc_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Ethernet header classifier package
// Transfer types, frame kind codes and header constants shared by the
// classifier modules.
// ============================================================================
package ehc_pkg;

    // One input transfer: a frame byte and its end-of-frame mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    // One classification result.
    typedef struct packed {
        logic [2:0]  frame_kind;
        logic        vlan_valid;
        logic [11:0] vlan_id;
        logic        type_valid;
        logic [15:0] inner_type;
        logic [4:0]  dest_offset;
        logic        source_valid;
        logic [4:0]  source_offset;
        logic        payload_valid;
        logic [5:0]  payload_offset;
        logic [13:0] payload_length;
    } result_t;

    // Frame kind codes.
    localparam logic [2:0] KIND_ERROR = 3'd0;
    localparam logic [2:0] KIND_DIX   = 3'd1;
    localparam logic [2:0] KIND_8023  = 3'd2;
    localparam logic [2:0] KIND_8021Q = 3'd3;
    localparam logic [2:0] KIND_8021AD = 3'd4;
    localparam logic [2:0] KIND_8021AH = 3'd5;

    // Outer type words.
    localparam logic [15:0] TYPE_8021Q   = 16'h8100;
    localparam logic [15:0] TYPE_8021AD  = 16'h88A8;
    localparam logic [15:0] TYPE_8021AH  = 16'h88E7;
    localparam logic [15:0] TYPE_LEN_MAX = 16'h05DC;
    localparam logic [15:0] VID_MASK     = 16'h0FFF;

    // Header sizes, which are also the payload offsets.
    localparam logic [5:0] HDR_DIX  = 6'd14;
    localparam logic [5:0] HDR_Q    = 6'd18;
    localparam logic [5:0] HDR_AD   = 6'd22;
    localparam logic [5:0] HDR_AH   = 6'd40;

    // Address offsets.
    localparam logic [4:0] SRC_OFF     = 5'd6;
    localparam logic [4:0] AH_DEST_OFF = 5'd18;
    localparam logic [4:0] AH_SRC_OFF  = 5'd24;

    // LLC/SNAP prefix bytes.
    localparam logic [7:0] SNAP_DSAP = 8'hAA;
    localparam logic [7:0] SNAP_CTRL = 8'h03;

endpackage

// ----- rtl/core/ehc_capture.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Ethernet header classifier: byte capture
// Counts the bytes of a frame with saturation, keeps the first header bytes
// and holds the captured length of a finished frame until it is classified.
// ============================================================================
module ehc_capture #(
    parameter int HEADER_BYTES = 40,
    parameter int MAX_FRAME    = 16383,
    parameter int CNT_W        = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ehc_pkg::item_t                item,
    input  logic                          accept,
    input  logic                          advance,
    output logic                          done_valid,
    output logic [CNT_W-1:0]              done_len,
    output logic [HEADER_BYTES-1:0][7:0]  header
);

    localparam int IDX_W = $clog2(HEADER_BYTES);

    logic [CNT_W-1:0]             pos_reg;
    logic [CNT_W-1:0]             pos_next;
    logic [CNT_W-1:0]             pos_inc;
    logic [CNT_W-1:0]             len_reg;
    logic                         done_valid_reg;
    logic                         done_valid_next;
    logic [HEADER_BYTES-1:0][7:0] hdr_reg;

    // Saturating byte count, cleared after the final byte of a frame.
    always_comb
    begin
        pos_inc = (pos_reg < CNT_W'(MAX_FRAME)) ? pos_reg + 1'b1 : pos_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            pos_next = item.last ? '0 : pos_inc;
        end
    end

    // A finished frame waits here until the result stage takes it.
    always_comb
    begin
        done_valid_next = done_valid_reg;
        if (advance)
        begin
            done_valid_next = 1'b0;
        end
        if (accept && item.last)
        begin
            done_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            done_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            done_valid_reg <= done_valid_next;
        end
    end

    // Captured length of the finished frame.
    always_ff @(posedge clk)
    begin
        if (accept && item.last)
        begin
            len_reg <= pos_inc;
        end
    end

    // Header store; bytes beyond its size are counted but not kept.
    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg < CNT_W'(HEADER_BYTES)))
        begin
            hdr_reg[pos_reg[IDX_W-1:0]] <= item.data_byte;
        end
    end

    assign done_valid = done_valid_reg;
    assign done_len   = len_reg;
    assign header     = hdr_reg;

endmodule

// ----- rtl/core/ehc_classify.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Ethernet header classifier: classification logic
// Decodes the outer type word and forms the tag, inner type, offsets and
// payload length from the captured header bytes and frame length.
// ============================================================================
module ehc_classify #(
    parameter int HEADER_BYTES = 40,
    parameter int CNT_W        = 14
) (
    input  logic [CNT_W-1:0]             len,
    input  logic [HEADER_BYTES-1:0][7:0] header,
    output ehc_pkg::result_t             result
);

    localparam int DIFF_W = (CNT_W > 14) ? CNT_W : 14;

    logic [15:0]       outer;
    logic              snap_ok;
    logic [DIFF_W-1:0] diff;

    always_comb
    begin
        outer = {header[12], header[13]};
        snap_ok = (header[14] == ehc_pkg::SNAP_DSAP) && (header[15] == ehc_pkg::SNAP_DSAP)
               && (header[16] == ehc_pkg::SNAP_CTRL) && (header[17] == 8'h00)
               && (header[18] == 8'h00) && (header[19] == 8'h00);

        result = '0;
        if (len >= CNT_W'(14))
        begin
            result.source_valid  = 1'b1;
            result.source_offset = ehc_pkg::SRC_OFF;
            // Outer type word selects the frame kind.
            if (outer == ehc_pkg::TYPE_8021Q)
            begin
                result.frame_kind     = ehc_pkg::KIND_8021Q;
                result.payload_offset = ehc_pkg::HDR_Q;
                if (len >= CNT_W'(16))
                begin
                    result.vlan_valid = 1'b1;
                    result.vlan_id    = 12'({header[14], header[15]} & ehc_pkg::VID_MASK);
                end
                if (len >= CNT_W'(18))
                begin
                    result.type_valid = 1'b1;
                    result.inner_type = {header[16], header[17]};
                end
            end
            else if (outer == ehc_pkg::TYPE_8021AD)
            begin
                result.frame_kind     = ehc_pkg::KIND_8021AD;
                result.payload_offset = ehc_pkg::HDR_AD;
                if (len >= CNT_W'(20))
                begin
                    result.vlan_valid = 1'b1;
                    result.vlan_id    = 12'({header[18], header[19]} & ehc_pkg::VID_MASK);
                end
                if (len >= CNT_W'(22))
                begin
                    result.type_valid = 1'b1;
                    result.inner_type = {header[20], header[21]};
                end
            end
            else if (outer == ehc_pkg::TYPE_8021AH)
            begin
                result.frame_kind     = ehc_pkg::KIND_8021AH;
                result.payload_offset = ehc_pkg::HDR_AH;
                result.dest_offset    = ehc_pkg::AH_DEST_OFF;
                result.source_offset  = ehc_pkg::AH_SRC_OFF;
                result.source_valid   = (len >= CNT_W'(30));
                if (len >= CNT_W'(38))
                begin
                    result.vlan_valid = 1'b1;
                    result.vlan_id    = 12'({header[36], header[37]} & ehc_pkg::VID_MASK);
                end
                if (len >= CNT_W'(40))
                begin
                    result.type_valid = 1'b1;
                    result.inner_type = {header[38], header[39]};
                end
            end
            else if (outer > ehc_pkg::TYPE_LEN_MAX)
            begin
                result.frame_kind     = ehc_pkg::KIND_DIX;
                result.payload_offset = ehc_pkg::HDR_DIX;
                result.type_valid     = 1'b1;
                result.inner_type     = outer;
            end
            else
            begin
                // 802.3 length frame; the type is known only behind LLC/SNAP.
                result.frame_kind     = ehc_pkg::KIND_8023;
                result.payload_offset = ehc_pkg::HDR_DIX;
                if ((len >= CNT_W'(22)) && snap_ok)
                begin
                    result.type_valid = 1'b1;
                    result.inner_type = {header[20], header[21]};
                end
            end
        end

        // Payload length beyond the header.
        diff = DIFF_W'(len) - DIFF_W'(result.payload_offset);
        if ((len >= CNT_W'(14)) && (len > CNT_W'(result.payload_offset)))
        begin
            result.payload_valid  = 1'b1;
            result.payload_length = diff[13:0];
        end
    end

endmodule

// ----- rtl/core/ethernet_header_classifier_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Ethernet header classifier
// Takes a frame one byte per transfer and gives one classification of its
// Ethernet header (kind, VLAN id, inner type, offsets, payload length) when
// the final byte has been transferred.
// ============================================================================
//
//  Channel  Signals                             Width    Role
//  -------  ----------------------------------  -------  -------------------
//  item     item_valid, item_stall, item        1,1,9    frame bytes in
//  result   result_valid, result_stall, result  1,1,65   classification out
//
//  One byte is taken in every cycle while item_stall is low; the counter and
//  header store update at the edge that takes the byte. The final byte of a
//  frame loads the finished-frame register; the result register is loaded from
//  the decode logic when it is free, and the classification is offered from it.
//  Reset clears the byte count and both valid flags; header bytes are not
//  cleared. item_stall rises only while a finished frame waits behind a
//  stalled result, so input keeps flowing while a result waits.
//
module ethernet_header_classifier_top #(
    parameter int HEADER_BYTES = 40,
    parameter int MAX_FRAME    = 16383
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  ehc_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output ehc_pkg::result_t result
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);

    logic                         accept;
    logic                         advance;
    logic                         done_valid;
    logic [CNT_W-1:0]             done_len;
    logic [HEADER_BYTES-1:0][7:0] header;
    ehc_pkg::result_t             class_result;
    ehc_pkg::result_t             result_reg;
    logic                         result_valid_reg;
    logic                         result_valid_next;

    // Handshake: a finished frame moves on when the result register is free.
    assign advance    = done_valid && (!result_valid_reg || !result_stall);
    assign item_stall = done_valid && !advance;
    assign accept     = item_valid && !item_stall;

    ehc_capture #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_FRAME    (MAX_FRAME),
        .CNT_W        (CNT_W)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .accept     (accept),
        .advance    (advance),
        .done_valid (done_valid),
        .done_len   (done_len),
        .header     (header)
    );

    ehc_classify #(
        .HEADER_BYTES (HEADER_BYTES),
        .CNT_W        (CNT_W)
    ) u_classify (
        .len    (done_len),
        .header (header),
        .result (class_result)
    );

    // Result register valid flag.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= class_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The input is held back only behind a finished frame and a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (done_valid && result_valid_reg && result_stall))
        else $error("item_stall raised without a blocked result");

    // An error result carries no other information.
    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.frame_kind == ehc_pkg::KIND_ERROR))
        |-> (!result.payload_valid && !result.source_valid && !result.type_valid
             && (result.payload_offset == '0)))
        else $error("error result with non-zero fields");

    // A VLAN id is reported only for tagged kinds.
    a_vlan_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.vlan_valid)
        |-> ((result.frame_kind == ehc_pkg::KIND_8021Q)
             || (result.frame_kind == ehc_pkg::KIND_8021AD)
             || (result.frame_kind == ehc_pkg::KIND_8021AH)))
        else $error("VLAN id on an untagged kind");

    // Invalid type and tag fields read as zero.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.type_valid || (result.inner_type == '0))
                          && (result.vlan_valid || (result.vlan_id == '0))))
        else $error("invalid field is not zero");

    // A frame taken by the result stage leaves the finished-frame register.
    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !(accept && item.last)) |=> !done_valid)
        else $error("finished frame not released after transfer");

endmodule
